// ===== src/mhld_pkg.sv =====
package mhld_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int ADDR_W = 8;
	localparam int CNT_W = 9;
	localparam int KEY_W = 32;
	localparam int ID_W = 8;
	localparam int ID_COUNT = 256;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACT,
		ST_UP_RD,
		ST_UP_CMP,
		ST_CHK_RD,
		ST_CHK,
		ST_MOVE,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DN_SWP,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic do_insert;
		logic do_delete;
		logic up_rd;
		logic up_swap;
		logic rd_top;
		logic pop_last;
		logic move_top;
		logic dn_rd;
		logic dn_swap;
		logic set_result;
	} dp_cmd_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic up_done;
		logic up_more;
		logic top_dead;
		logic count_zero;
		logic dn_leaf;
		logic dn_more;
	} dp_sts_t;

endpackage

// ===== src/min_heap_lazy_delete.sv =====
// Binary min-heap of (signed key, id) pairs with lazy deletion.
// Input channel in_valid/in_ready carries action, key and id: insert,
// mark an id inactive, or peek (any other code also peeks).
// Output channel out_valid/out_ready gives one item per input: the
// smallest live key and id, empty_res when none is live, and overflow
// when an insert found the heap full and was dropped.
// After acceptance the action is applied, an insert sifts its entry up,
// and each dead top entry is replaced by the last entry, which sinks;
// cleanup may remove several of them. The top is then registered.
// One item is processed at a time: the next is taken, at the earliest,
// in the cycle in which the receiver takes the result.
// Reset empties the heap and clears all active marks at once.
// A finished result is held in the output register while the receiver
// stalls, and no new item is taken until that result has been taken.
module min_heap_lazy_delete (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] key,
	input  logic [7:0]         id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] min_key,
	output logic [7:0]         min_id,
	output logic               empty_res,
	output logic               overflow
);
	import mhld_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mhld_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .action,
		.out_valid, .out_ready, .cmd, .sts
	);

	mhld_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .key, .id,
		.min_key, .min_id, .empty_res, .overflow
	);
endmodule

// ===== src/mhld_datapath.sv =====
module mhld_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  mhld_pkg::dp_cmd_t  cmd,
	output mhld_pkg::dp_sts_t  sts,
	input  logic signed [31:0] key,
	input  logic [7:0]         id,
	output logic signed [31:0] min_key,
	output logic [7:0]         min_id,
	output logic               empty_res,
	output logic               overflow
);
	import mhld_pkg::*;

	logic [KEY_W-1:0] keys_mem [HEAP_DEPTH];
	logic [ID_W-1:0]  ids_mem [HEAP_DEPTH];
	logic [ID_COUNT-1:0] marks_q;
	logic [CNT_W-1:0] count_q;
	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0]  id_q;
	logic [ADDR_W-1:0] pos_q;
	logic [KEY_W-1:0] pk_q, ck_q, rk_q;
	logic [ID_W-1:0]  pi_q, ci_q, ri_q;
	logic [ADDR_W-1:0] par_a;
	logic [CNT_W:0] left_w, right_w;
	logic pick_r, ovf_q;
	logic [KEY_W-1:0] sel_k;
	logic [ID_W-1:0]  sel_i;
	logic [ADDR_W-1:0] sel_a;

	assign par_a = ADDR_W'((pos_q - 1'b1) >> 1);
	assign left_w = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + 1'b1;
	assign pick_r = (right_w < (CNT_W+1)'(count_q)) && !($signed(ck_q) < $signed(rk_q));
	assign sel_k = pick_r ? rk_q : ck_q;
	assign sel_i = pick_r ? ri_q : ci_q;
	assign sel_a = pick_r ? ADDR_W'(right_w) : ADDR_W'(left_w);

	always_comb begin
		sts.up_done = (pos_q == '0);
		sts.up_more = $signed(ck_q) < $signed(pk_q);
		sts.top_dead = !marks_q[pi_q];
		sts.count_zero = (count_q == '0);
		sts.dn_leaf = left_w >= (CNT_W+1)'(count_q);
		sts.dn_more = $signed(sel_k) < $signed(pk_q);
	end

	// Heap storage: one read pair and one write pair per cycle each.
	always_ff @(posedge clk) begin
		if (cmd.do_insert && !count_q[CNT_W-1]) begin
			keys_mem[ADDR_W'(count_q)] <= key_q;
			ids_mem[ADDR_W'(count_q)] <= id_q;
		end
		if (cmd.up_rd) begin
			ck_q <= keys_mem[pos_q];
			ci_q <= ids_mem[pos_q];
			pk_q <= keys_mem[par_a];
			pi_q <= ids_mem[par_a];
		end
		if (cmd.up_swap) begin
			keys_mem[par_a] <= ck_q;
			ids_mem[par_a] <= ci_q;
			keys_mem[pos_q] <= pk_q;
			ids_mem[pos_q] <= pi_q;
		end
		if (cmd.rd_top) begin
			pk_q <= keys_mem[0];
			pi_q <= ids_mem[0];
		end
		if (cmd.pop_last) begin
			ck_q <= keys_mem[ADDR_W'(count_q - 1'b1)];
			ci_q <= ids_mem[ADDR_W'(count_q - 1'b1)];
		end
		if (cmd.move_top) begin
			keys_mem[0] <= ck_q;
			ids_mem[0] <= ci_q;
			pk_q <= ck_q;
			pi_q <= ci_q;
		end
		if (cmd.dn_rd) begin
			ck_q <= keys_mem[ADDR_W'(left_w)];
			ci_q <= ids_mem[ADDR_W'(left_w)];
			rk_q <= keys_mem[ADDR_W'(right_w)];
			ri_q <= ids_mem[ADDR_W'(right_w)];
		end
		if (cmd.dn_swap) begin
			keys_mem[sel_a] <= pk_q;
			ids_mem[sel_a] <= pi_q;
			keys_mem[pos_q] <= sel_k;
			ids_mem[pos_q] <= sel_i;
		end
		if (cmd.capture) begin
			key_q <= key;
			id_q <= id;
		end
	end

	// Control registers: count, marks, position and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			marks_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			min_key <= '0;
			min_id <= '0;
			empty_res <= 1'b0;
			overflow <= 1'b0;
		end else begin
			if (cmd.capture) ovf_q <= 1'b0;
			if (cmd.do_insert) begin
				// A dropped insert parks the position at the root so no sift-up follows.
				if (count_q[CNT_W-1]) begin
					ovf_q <= 1'b1;
					pos_q <= '0;
				end else begin
					marks_q[id_q] <= 1'b1;
					pos_q <= ADDR_W'(count_q);
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.do_delete) marks_q[id_q] <= 1'b0;
			if (cmd.up_swap) pos_q <= par_a;
			if (cmd.pop_last) count_q <= count_q - 1'b1;
			if (cmd.move_top) pos_q <= '0;
			if (cmd.dn_swap) pos_q <= sel_a;
			if (cmd.set_result) begin
				empty_res <= (count_q == '0);
				min_key <= (count_q == '0) ? '0 : $signed(pk_q);
				min_id <= (count_q == '0) ? '0 : pi_q;
				overflow <= ovf_q;
			end
		end
	end
endmodule

// ===== src/mhld_ctrl.sv =====
module mhld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	output logic              out_valid,
	input  logic              out_ready,
	output mhld_pkg::dp_cmd_t cmd,
	input  mhld_pkg::dp_sts_t sts
);
	import mhld_pkg::*;

	state_t state_q, state_d;
	logic [1:0] act_q;
	logic ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) act_q <= action;
			if (state_q == ST_OUT) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;
	// A new item may enter while the previous result still waits only if the receiver takes that result in the same cycle.
	assign in_ready = (state_q == ST_IDLE) && (!ovalid_q || out_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid && in_ready) state_d = ST_ACT;
			ST_ACT:    state_d = (act_q == ACT_INSERT) ? ST_UP_RD : ST_CHK_RD;
			ST_UP_RD:  state_d = sts.up_done ? ST_CHK_RD : ST_UP_CMP;
			ST_UP_CMP: state_d = sts.up_more ? ST_UP_RD : ST_CHK_RD;
			ST_CHK_RD: state_d = ST_CHK;
			ST_CHK:    state_d = (sts.count_zero || !sts.top_dead) ? ST_OUT : ST_MOVE;
			ST_MOVE:   state_d = ST_DN_RD;
			ST_DN_RD:  state_d = sts.dn_leaf ? ST_CHK_RD : ST_DN_CMP;
			ST_DN_CMP: state_d = sts.dn_more ? ST_DN_SWP : ST_CHK_RD;
			ST_DN_SWP: state_d = ST_DN_RD;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.capture = in_valid && in_ready;
			ST_ACT: begin
				cmd.do_insert = (act_q == ACT_INSERT);
				cmd.do_delete = (act_q == ACT_DELETE);
			end
			ST_UP_RD:  cmd.up_rd = 1'b1;
			ST_UP_CMP: cmd.up_swap = sts.up_more;
			ST_CHK_RD: cmd.rd_top = 1'b1;
			ST_CHK:    cmd.pop_last = !sts.count_zero && sts.top_dead;
			ST_MOVE:   cmd.move_top = 1'b1;
			ST_DN_RD:  cmd.dn_rd = 1'b1;
			ST_DN_CMP: ;
			ST_DN_SWP: cmd.dn_swap = 1'b1;
			ST_OUT:    cmd.set_result = 1'b1;
			default:   ;
		endcase
	end
endmodule
